// ----- sv/pwm_pkg.sv -----
// Shared types and constants for the pressure window monitor.
package pwm_pkg;

   localparam int PRES_W   = 12;
   localparam int ID_W     = 8;
   localparam int LEVEL_W  = 3;
   localparam int ABN_W    = 5;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 4;

   typedef enum logic [LEVEL_W-1:0] {
      LVL_NORMAL    = 3'd0,
      LVL_LOW_WARN  = 3'd1,
      LVL_LOW_CRIT  = 3'd2,
      LVL_HIGH_WARN = 3'd3,
      LVL_HIGH_CRIT = 3'd4
   } level_type;

   typedef enum logic [STATUS_W-1:0] {
      SYS_NORMAL   = 2'd0,
      SYS_WARNING  = 2'd1,
      SYS_CRITICAL = 2'd2
   } sys_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_WARNING   = 4'd0,
      CSR_LOW_CRITICAL  = 4'd1,
      CSR_HIGH_WARNING  = 4'd2,
      CSR_HIGH_CRITICAL = 4'd3
   } csr_index_type;

   localparam logic [PRES_W-1:0] LOW_WARNING_RST   = 12'd150;
   localparam logic [PRES_W-1:0] LOW_CRITICAL_RST  = 12'd80;
   localparam logic [PRES_W-1:0] HIGH_WARNING_RST  = 12'd350;
   localparam logic [PRES_W-1:0] HIGH_CRITICAL_RST = 12'd450;

   // controller -> datapath
   typedef struct packed {
      logic take;      // input transaction accepted this cycle
      logic div_step;  // run one divider iteration
   } pwm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_last;  // current divider iteration is the final one
   } pwm_stat_type;

endpackage

// ----- sv/pwm_ctrl.sv -----
// Controller state machine: handshakes, result valid and divider sequencing.
module pwm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output pwm_pkg::pwm_cmd_type  cmd,
   input  pwm_pkg::pwm_stat_type stat
);
   import pwm_pkg::*;

   typedef enum logic {
      ST_RUN,
      ST_DIV
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign req_ready    = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign take         = req_valid && req_ready;
   assign cmd.take     = take;
   assign cmd.div_step = (state_ff == ST_DIV);
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_RUN: begin
            if (take) begin
               if (req_last) begin
                  // summary waits for the divider
                  state_in     = ST_DIV;
                  rsp_valid_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (stat.div_last) begin
               state_in     = ST_RUN;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_RUN;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      take && req_last |=> !rsp_valid_ff && state_ff == ST_DIV)
      else $error("last transaction did not start the divider");

   a_plain_result: assert property (@(posedge clock) disable iff (reset)
      take && !req_last |=> rsp_valid_ff && state_ff == ST_RUN)
      else $error("classification result not presented");

   a_div_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && stat.div_last |=> rsp_valid_ff && state_ff == ST_RUN)
      else $error("summary result not presented after divide");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !rsp_valid_ff)
      else $error("result pending while divider busy");

endmodule

// ----- sv/pwm_datapath.sv -----
// Datapath: thresholds, classification, batch accumulators, serial divider, result register.
module pwm_datapath #(
   parameter int MAX_READINGS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pwm_pkg::pwm_cmd_type                cmd,
   output pwm_pkg::pwm_stat_type               stat,
   input  logic                                csr_valid,
   input  logic [pwm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pwm_pkg::PRES_W-1:0]          csr_wdata,
   input  logic [pwm_pkg::ID_W-1:0]            req_sensor_id,
   input  logic [pwm_pkg::PRES_W-1:0]          req_pressure,
   input  logic                                req_last,
   output logic [pwm_pkg::ID_W-1:0]            rsp_reading_id,
   output logic [pwm_pkg::LEVEL_W-1:0]         rsp_level,
   output logic                                rsp_summary_valid,
   output logic [pwm_pkg::PRES_W-1:0]          rsp_average,
   output logic [pwm_pkg::ID_W-1:0]            rsp_lowest_id,
   output logic [pwm_pkg::PRES_W-1:0]          rsp_lowest_value,
   output logic [pwm_pkg::ID_W-1:0]            rsp_highest_id,
   output logic [pwm_pkg::PRES_W-1:0]          rsp_highest_value,
   output logic [pwm_pkg::ABN_W-1:0]           rsp_abnormal_count,
   output logic [pwm_pkg::STATUS_W-1:0]        rsp_system_status
);
   import pwm_pkg::*;

   localparam int CW     = $clog2(MAX_READINGS + 1);
   localparam int SW     = PRES_W + CW;
   localparam int STEP_W = $clog2(SW);

   // thresholds
   logic [PRES_W-1:0] low_warn_ff, low_crit_ff, high_warn_ff, high_crit_ff;

   // batch state
   logic [SW-1:0]     sum_ff, sum_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     oow_ff, oow_in;
   logic [PRES_W-1:0] min_val_ff, min_val_in, max_val_ff, max_val_in;
   logic [ID_W-1:0]   min_id_ff, min_id_in, max_id_ff, max_id_in;

   // divider
   logic [SW-1:0]     quo_ff, quo_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     den_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CW:0]       shifted;
   logic              ge;

   // result register
   logic [ID_W-1:0]     rid_ff, lo_id_ff, hi_id_ff;
   level_type           level_ff, level_in;
   logic                sumv_ff;
   logic [PRES_W-1:0]   avg_ff, lo_val_ff, hi_val_ff;
   logic [ABN_W-1:0]    abn_ff;
   sys_status_type      sys_ff, sys_in;

   logic room, abnormal;

   assign room     = (cnt_ff != CW'(MAX_READINGS));
   assign abnormal = (req_pressure < low_warn_ff) || (req_pressure > high_warn_ff);

   always_comb begin
      if (req_pressure < low_crit_ff)       level_in = LVL_LOW_CRIT;
      else if (req_pressure < low_warn_ff)  level_in = LVL_LOW_WARN;
      else if (req_pressure > high_crit_ff) level_in = LVL_HIGH_CRIT;
      else if (req_pressure > high_warn_ff) level_in = LVL_HIGH_WARN;
      else                                  level_in = LVL_NORMAL;
   end

   always_comb begin
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      oow_in     = oow_ff;
      min_val_in = min_val_ff;
      min_id_in  = min_id_ff;
      max_val_in = max_val_ff;
      max_id_in  = max_id_ff;
      if (room) begin
         sum_in = sum_ff + SW'(req_pressure);
         cnt_in = cnt_ff + CW'(1);
         if (abnormal) oow_in = oow_ff + CW'(1);
         if (cnt_ff == '0 || req_pressure < min_val_ff) begin
            min_val_in = req_pressure;
            min_id_in  = req_sensor_id;
         end
         if (cnt_ff == '0 || req_pressure > max_val_ff) begin
            max_val_in = req_pressure;
            max_id_in  = req_sensor_id;
         end
      end
      if (min_val_in < low_crit_ff || max_val_in > high_crit_ff) sys_in = SYS_CRITICAL;
      else if (oow_in != '0)                                     sys_in = SYS_WARNING;
      else                                                       sys_in = SYS_NORMAL;
   end

   // restoring divide, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[SW-1]};
   assign ge      = (shifted >= {1'b0, den_ff});
   assign rem_in  = ge ? CW'(shifted - {1'b0, den_ff}) : shifted[CW-1:0];
   assign quo_in  = {quo_ff[SW-2:0], ge};
   assign stat.div_last = (step_ff == STEP_W'(SW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         low_warn_ff  <= LOW_WARNING_RST;
         low_crit_ff  <= LOW_CRITICAL_RST;
         high_warn_ff <= HIGH_WARNING_RST;
         high_crit_ff <= HIGH_CRITICAL_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOW_WARNING:   low_warn_ff  <= csr_wdata;
            CSR_LOW_CRITICAL:  low_crit_ff  <= csr_wdata;
            CSR_HIGH_WARNING:  high_warn_ff <= csr_wdata;
            CSR_HIGH_CRITICAL: high_crit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         cnt_ff     <= '0;
         oow_ff     <= '0;
         min_val_ff <= '0;
         min_id_ff  <= '0;
         max_val_ff <= '0;
         max_id_ff  <= '0;
      end else if (cmd.take) begin
         if (req_last) begin
            sum_ff     <= '0;
            cnt_ff     <= '0;
            oow_ff     <= '0;
            min_val_ff <= '0;
            min_id_ff  <= '0;
            max_val_ff <= '0;
            max_id_ff  <= '0;
         end else begin
            sum_ff     <= sum_in;
            cnt_ff     <= cnt_in;
            oow_ff     <= oow_in;
            min_val_ff <= min_val_in;
            min_id_ff  <= min_id_in;
            max_val_ff <= max_val_in;
            max_id_ff  <= max_id_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.take) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         quo_ff <= sum_in;
         den_ff <= cnt_in;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rid_ff   <= req_sensor_id;
         level_ff <= level_in;
         avg_ff   <= '0;
         if (req_last) begin
            sumv_ff   <= 1'b1;
            lo_id_ff  <= min_id_in;
            lo_val_ff <= min_val_in;
            hi_id_ff  <= max_id_in;
            hi_val_ff <= max_val_in;
            abn_ff    <= ABN_W'(oow_in);
            sys_ff    <= sys_in;
         end else begin
            sumv_ff   <= 1'b0;
            lo_id_ff  <= '0;
            lo_val_ff <= '0;
            hi_id_ff  <= '0;
            hi_val_ff <= '0;
            abn_ff    <= '0;
            sys_ff    <= SYS_NORMAL;
         end
      end else if (cmd.div_step && stat.div_last) begin
         avg_ff <= quo_in[PRES_W-1:0];
      end
   end

   assign rsp_reading_id     = rid_ff;
   assign rsp_level          = level_ff;
   assign rsp_summary_valid  = sumv_ff;
   assign rsp_average        = avg_ff;
   assign rsp_lowest_id      = lo_id_ff;
   assign rsp_lowest_value   = lo_val_ff;
   assign rsp_highest_id     = hi_id_ff;
   assign rsp_highest_value  = hi_val_ff;
   assign rsp_abnormal_count = abn_ff;
   assign rsp_system_status  = sys_ff;

endmodule

// ----- sv/pressure_window_monitor_core.sv -----
// Top level of the pressure window monitor: controller plus datapath.
// Ordinary reading: result the next cycle, one per cycle while results are taken.
// Batch-closing reading (last): the average comes from a restoring divider that
// yields one quotient bit per cycle across the 12 + clog2(MAX_READINGS+1) bit sum
// (17 bits at the default); the result is registered with the last quotient bit.
// Synchronous active-high reset: thresholds back to 150/80/350/450, batch cleared.
module pressure_window_monitor_core #(
   parameter int MAX_READINGS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // input readings
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pwm_pkg::ID_W-1:0]       req_sensor_id,
   input  logic [pwm_pkg::PRES_W-1:0]     req_pressure,
   input  logic                           req_last,
   // results
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pwm_pkg::ID_W-1:0]       rsp_reading_id,
   output logic [pwm_pkg::LEVEL_W-1:0]    rsp_level,
   output logic                           rsp_summary_valid,
   output logic [pwm_pkg::PRES_W-1:0]     rsp_average,
   output logic [pwm_pkg::ID_W-1:0]       rsp_lowest_id,
   output logic [pwm_pkg::PRES_W-1:0]     rsp_lowest_value,
   output logic [pwm_pkg::ID_W-1:0]       rsp_highest_id,
   output logic [pwm_pkg::PRES_W-1:0]     rsp_highest_value,
   output logic [pwm_pkg::ABN_W-1:0]      rsp_abnormal_count,
   output logic [pwm_pkg::STATUS_W-1:0]   rsp_system_status,
   // threshold register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pwm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pwm_pkg::PRES_W-1:0]     csr_wdata
);
   import pwm_pkg::*;

   pwm_cmd_type  cmd;
   pwm_stat_type stat;

   // Threshold writes are always accepted and registered; indexes past the list are dropped.
   assign csr_ready = 1'b1;

   // Controller owns req_ready/rsp_valid; a pending result does not block the
   // next ordinary transaction when the consumer takes it in the same cycle.
   pwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath: thresholds, classification, batch statistics, divider and result register.
   pwm_datapath #(
      .MAX_READINGS (MAX_READINGS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_sensor_id      (req_sensor_id),
      .req_pressure       (req_pressure),
      .req_last           (req_last),
      .rsp_reading_id     (rsp_reading_id),
      .rsp_level          (rsp_level),
      .rsp_summary_valid  (rsp_summary_valid),
      .rsp_average        (rsp_average),
      .rsp_lowest_id      (rsp_lowest_id),
      .rsp_lowest_value   (rsp_lowest_value),
      .rsp_highest_id     (rsp_highest_id),
      .rsp_highest_value  (rsp_highest_value),
      .rsp_abnormal_count (rsp_abnormal_count),
      .rsp_system_status  (rsp_system_status)
   );

endmodule
